FILE: rtl/core/nane_pkg.sv
// Package for the NAND array netlist evaluator.
// Holds the field widths, request codes and the sequencer state type.
// Depends on nothing; used by the top level in rtl/core.
`default_nettype none

package nane_pkg;

  // Widths of the word fields at the ports.
  localparam int REQ_W      = 1;
  localparam int SINK_W     = 8;
  localparam int NODE_W     = 7;
  localparam int VEC_W      = 8;
  localparam int VEC_IDX_W  = 3;
  localparam int RES_W      = 4;

  // Request codes carried by in_req_type.
  localparam logic [REQ_W-1:0] REQ_LOAD = 1'b0;
  localparam logic [REQ_W-1:0] REQ_EVAL = 1'b1;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RDA  = 5'b00010,
    S_RDB  = 5'b00100,
    S_GB   = 5'b01000,
    S_WR   = 5'b10000
  } state_t;

endpackage

`default_nettype wire

FILE: rtl/core/nane_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the wire table and the gate value store; depends on nothing.
`default_nettype none

module nane_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/nand_array_netlist_evaluator.sv
// Top level of the NAND array netlist evaluator: sequencer, wire table and gate store.
// Depends on nane_pkg and nane_ram.
`default_nettype none

// How to use this block:
// A word is taken on the in_ ports at a rising edge where start is high and
// busy is low. A load word (in_req_type = 0) wires one sink pin to a source
// node in that same cycle; busy never rises for it and no result follows.
// An evaluate word (in_req_type = 1) latches the input vector and raises
// busy while the sequencer walks every gate in index order and then every
// primary output. The walk goes through one wire-table read port and one
// gate-store read port, so each gate or output with its first pin wired
// passes through S_RDA, S_RDB, S_GB and S_WR, and each with its first pin
// unwired only through S_RDA. Busy drops in the cycle where out_valid pulses
// high for one cycle with the result word on out_output_vector and
// out_outputs_used.
// The receiver cannot hold a result off; it must take it in that cycle.
// Reset (rst_n low, synchronous) marks every sink unwired and every gate value
// unset, clears output values and used flags, and returns the sequencer to idle.
// The wire table and gate store contents are not cleared; valid flags cover them.
module nand_array_netlist_evaluator #(
  parameter int NUM_INPUTS       = 8,
  parameter int NUM_OUTPUTS      = 4,
  parameter int GATES_PER_COLUMN = 10,
  parameter int NUM_COLUMNS      = 10
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [nane_pkg::REQ_W-1:0]  in_req_type,
  input  wire logic [nane_pkg::SINK_W-1:0] in_sink_pin,
  input  wire logic [nane_pkg::NODE_W-1:0] in_source_node,
  input  wire logic [nane_pkg::VEC_W-1:0]  in_input_vector,
  output logic                             out_valid,
  output logic      [nane_pkg::RES_W-1:0]  out_output_vector,
  output logic      [nane_pkg::RES_W-1:0]  out_outputs_used
);

  localparam int GATE_COUNT = GATES_PER_COLUMN * NUM_COLUMNS;
  localparam int SINK_COUNT = 2 * GATE_COUNT + NUM_OUTPUTS;
  localparam int ITEM_COUNT = GATE_COUNT + NUM_OUTPUTS;
  localparam int WA_W   = (SINK_COUNT > 1) ? $clog2(SINK_COUNT) : 1;
  localparam int GIDX_W = (GATE_COUNT > 1) ? $clog2(GATE_COUNT) : 1;
  localparam int OIDX_W = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;
  localparam int CNT_W  = (ITEM_COUNT > 1) ? $clog2(ITEM_COUNT) : 1;

  nane_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0]              idx_r, idx_nxt;
  logic [nane_pkg::VEC_W-1:0]    vec_r;
  logic [SINK_COUNT-1:0]         wire_set_r;
  logic [GATE_COUNT-1:0]         gate_set_r;
  logic [NUM_OUTPUTS-1:0]        out_val_r;
  logic [NUM_OUTPUTS-1:0]        used_r;
  logic                          out_valid_r;
  logic                          b_valid_r;
  logic                          pend_gate_r;
  logic                          pend_in_r;
  logic                          a_r;

  logic                          accept;
  logic                          load_wr;
  logic                          is_out;
  logic                          last_item;
  logic [WA_W-1:0]               pin0_addr;
  logic [WA_W-1:0]               wire_raddr;
  logic [nane_pkg::NODE_W-1:0]   wire_rdata;
  logic                          wire_we;
  logic                          gate_we;
  logic [GIDX_W-1:0]             gate_raddr;
  logic [0:0]                    gate_rdata;
  logic                          dec_use_gate;
  logic                          dec_in_val;
  logic [GIDX_W-1:0]             dec_gidx;
  logic                          node_val;
  logic                          b_val;

  assign busy    = (state_r != nane_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign load_wr = accept && (in_req_type == nane_pkg::REQ_LOAD)
                   && (int'(in_sink_pin) < SINK_COUNT);

  // Current item: gates first, then primary outputs.
  assign is_out    = (int'(idx_r) >= GATE_COUNT);
  assign last_item = (int'(idx_r) == ITEM_COUNT - 1);
  assign pin0_addr = is_out ? WA_W'(int'(idx_r) + GATE_COUNT) : WA_W'(2 * int'(idx_r));

  // Wire table read address: first pin in S_RDA, second pin in S_RDB.
  always_comb begin
    wire_raddr = pin0_addr;
    if (state_r == nane_pkg::S_RDB) begin
      wire_raddr = pin0_addr + WA_W'(1);
    end
  end

  assign wire_we = load_wr;

  nane_ram #(
    .WIDTH(nane_pkg::NODE_W),
    .DEPTH(SINK_COUNT)
  ) u_wire_ram (
    .clk  (clk),
    .we   (wire_we),
    .waddr(WA_W'(in_sink_pin)),
    .wdata(in_source_node),
    .raddr(wire_raddr),
    .rdata(wire_rdata)
  );

  // Decode the source node just read: a primary input bit or a gate output.
  always_comb begin
    dec_in_val   = 1'b0;
    dec_use_gate = 1'b0;
    dec_gidx     = GIDX_W'(int'(wire_rdata) - NUM_INPUTS);
    if (int'(wire_rdata) < NUM_INPUTS) begin
      if (int'(wire_rdata) < nane_pkg::VEC_W) begin
        dec_in_val = vec_r[wire_rdata[nane_pkg::VEC_IDX_W-1:0]];
      end
    end else if (int'(wire_rdata) - NUM_INPUTS < GATE_COUNT) begin
      dec_use_gate = gate_set_r[dec_gidx];
    end
  end

  assign gate_raddr = dec_gidx;
  assign node_val   = pend_gate_r ? gate_rdata[0] : pend_in_r;
  assign b_val      = b_valid_r && node_val;
  assign gate_we    = (state_r == nane_pkg::S_WR) && !is_out;

  nane_ram #(
    .WIDTH(1),
    .DEPTH(GATE_COUNT)
  ) u_gate_ram (
    .clk  (clk),
    .we   (gate_we),
    .waddr(GIDX_W'(idx_r)),
    .wdata(~(a_r & b_val)),
    .raddr(gate_raddr),
    .rdata(gate_rdata)
  );

  // Sequencer: per item read pin 0; if wired, read pin 1, fetch operands, write back.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    unique case (state_r)
      nane_pkg::S_IDLE: begin
        if (accept && (in_req_type == nane_pkg::REQ_EVAL)) begin
          state_nxt = nane_pkg::S_RDA;
          idx_nxt   = '0;
        end
      end
      nane_pkg::S_RDA: begin
        if (wire_set_r[pin0_addr]) begin
          state_nxt = nane_pkg::S_RDB;
        end else if (last_item) begin
          state_nxt = nane_pkg::S_IDLE;
        end else begin
          idx_nxt = idx_r + CNT_W'(1);
        end
      end
      nane_pkg::S_RDB: state_nxt = nane_pkg::S_GB;
      nane_pkg::S_GB:  state_nxt = nane_pkg::S_WR;
      nane_pkg::S_WR: begin
        if (last_item) begin
          state_nxt = nane_pkg::S_IDLE;
        end else begin
          state_nxt = nane_pkg::S_RDA;
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end
      default: state_nxt = nane_pkg::S_IDLE;
    endcase
  end

  // Control registers and the flag arrays that reset clears.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nane_pkg::S_IDLE;
      idx_r       <= '0;
      wire_set_r  <= '0;
      gate_set_r  <= '0;
      out_val_r   <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= busy && (state_nxt == nane_pkg::S_IDLE);
      if (load_wr) begin
        wire_set_r[WA_W'(in_sink_pin)] <= 1'b1;
        if (int'(in_sink_pin) >= 2 * GATE_COUNT) begin
          used_r[OIDX_W'(int'(in_sink_pin) - 2 * GATE_COUNT)] <= 1'b1;
        end
      end
      if (gate_we) begin
        gate_set_r[GIDX_W'(idx_r)] <= 1'b1;
      end
      if ((state_r == nane_pkg::S_WR) && is_out) begin
        out_val_r[OIDX_W'(int'(idx_r) - GATE_COUNT)] <= a_r;
      end
    end
  end

  // Operand pipeline registers; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      vec_r <= in_input_vector;
    end
    if (state_r == nane_pkg::S_RDA) begin
      b_valid_r <= wire_set_r[pin0_addr + WA_W'(1)] && !is_out;
    end
    if ((state_r == nane_pkg::S_RDB) || (state_r == nane_pkg::S_GB)) begin
      pend_gate_r <= dec_use_gate;
      pend_in_r   <= dec_in_val;
    end
    if (state_r == nane_pkg::S_GB) begin
      a_r <= node_val;
    end
  end

  // Result word; outputs beyond the fourth are not shown.
  assign out_valid = out_valid_r;
  for (genvar k = 0; k < nane_pkg::RES_W; k++) begin : g_res
    if (k < NUM_OUTPUTS) begin : g_on
      assign out_output_vector[k] = out_val_r[k];
      assign out_outputs_used[k]  = used_r[k];
    end else begin : g_off
      assign out_output_vector[k] = 1'b0;
      assign out_outputs_used[k]  = 1'b0;
    end
  end

  // A result only appears once the walk has finished.
  a_res_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == nane_pkg::S_IDLE))
    else $error("result strobe while sequencer busy");

  // Write-back always follows the operand fetch.
  a_wr_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == nane_pkg::S_WR) |-> ($past(state_r) == nane_pkg::S_GB))
    else $error("write-back without operand fetch");

  // An accepted evaluate word starts the walk.
  a_eval_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == nane_pkg::REQ_EVAL)) |=> busy)
    else $error("evaluate word did not raise busy");

  // A load word never raises busy.
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == nane_pkg::REQ_LOAD)) |=> !busy && !out_valid_r)
    else $error("load word started the sequencer");

  // The result strobe is a pulse; it is never held high.
  a_one_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

endmodule

`default_nettype wire
